[rtl/aodv_route_table_core_assert.svh]
// Assertion macros used by the checker file of the route table.
`ifndef AODV_ROUTE_TABLE_CORE_ASSERT_SVH
`define AODV_ROUTE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("route table check failed");

// Next-cycle implication, checked outside reset.
`define RT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("route table check failed");

// Implication that is also checked while reset is applied.
`define RT_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error("route table check failed");

`endif

[rtl/aodv_rt_pkg.sv]
package aodv_rt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    // Fixed field widths.
    localparam int ACT_W   = 2;
    localparam int NODE_W  = 32;
    localparam int HOPS_W  = 8;
    localparam int SEQ_W   = 32;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_OUT_W = 7;
    localparam int LIMIT_W = 7;

    // Configuration port.
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic [0:0] REG_IDX_ROUTE_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] ROUTE_LIMIT_RST = 7'd64;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_REPLY = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ERROR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SWEEP = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_NEW      = 2'd0;
    localparam logic [STAT_W-1:0] ST_IMPROVED = 2'd1;
    localparam logic [STAT_W-1:0] ST_KEPT     = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0] dest;
        logic [NODE_W-1:0] nexthop;
        logic [HOPS_W-1:0] hops;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] expiry;
        logic              act;
    } t_entry;

    // Field groups of a table write: key covers destination and expiry,
    // route covers next hop, hop count and sequence number.
    typedef struct packed {
        logic   key_en;
        logic   route_en;
        logic   act_en;
        t_entry data;
    } t_mem_wr;

endpackage

[rtl/aodv_rt_if.sv]
interface aodv_rt_req_if import aodv_rt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [NODE_W-1:0] dest_node;
    logic [NODE_W-1:0] sender_node;
    logic [HOPS_W-1:0] hops;
    logic [SEQ_W-1:0]  seq_number;
    logic [TIME_W-1:0] route_lifetime;
    logic [NODE_W-1:0] lost_node;
    logic [TIME_W-1:0] time_now;

    modport source (
        output valid, action, dest_node, sender_node, hops, seq_number,
               route_lifetime, lost_node, time_now,
        input  ready
    );
    modport sink (
        input  valid, action, dest_node, sender_node, hops, seq_number,
               route_lifetime, lost_node, time_now,
        output ready
    );
endinterface

interface aodv_rt_rsp_if import aodv_rt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [CNT_OUT_W-1:0] affected;
    logic [CNT_OUT_W-1:0] used_entries;

    modport source (output valid, status, affected, used_entries, input ready);
    modport sink (input valid, status, affected, used_entries, output ready);
endinterface

[rtl/aodv_rt_mem.sv]
module aodv_rt_mem import aodv_rt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rd_en,
    input  logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] i_rd_addr,
    output t_entry                                    o_rd_entry,
    input  t_mem_wr                                   i_wr,
    input  logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] i_wr_addr
);

    logic [NODE_W-1:0] r_dest_mem    [TABLE_DEPTH];
    logic [NODE_W-1:0] r_nexthop_mem [TABLE_DEPTH];
    logic [HOPS_W-1:0] r_hops_mem    [TABLE_DEPTH];
    logic [SEQ_W-1:0]  r_seq_mem     [TABLE_DEPTH];
    logic [TIME_W-1:0] r_expiry_mem  [TABLE_DEPTH];
    logic              r_act_mem     [TABLE_DEPTH];
    t_entry            r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr.key_en) begin
            r_dest_mem[i_wr_addr]   <= i_wr.data.dest;
            r_expiry_mem[i_wr_addr] <= i_wr.data.expiry;
        end
        if (i_wr.route_en) begin
            r_nexthop_mem[i_wr_addr] <= i_wr.data.nexthop;
            r_hops_mem[i_wr_addr]    <= i_wr.data.hops;
            r_seq_mem[i_wr_addr]     <= i_wr.data.seq;
        end
        if (i_wr.act_en) begin
            r_act_mem[i_wr_addr] <= i_wr.data.act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_entry.dest    <= r_dest_mem[i_rd_addr];
            r_rd_entry.nexthop <= r_nexthop_mem[i_rd_addr];
            r_rd_entry.hops    <= r_hops_mem[i_rd_addr];
            r_rd_entry.seq     <= r_seq_mem[i_rd_addr];
            r_rd_entry.expiry  <= r_expiry_mem[i_rd_addr];
            r_rd_entry.act     <= r_act_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

[rtl/aodv_rt_seq.sv]
module aodv_rt_seq import aodv_rt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [LIMIT_W-1:0]   i_route_limit,
    aodv_rt_req_if.sink          i_req,
    aodv_rt_rsp_if.source        o_rsp,
    output logic                 o_rd_en,
    output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] o_rd_addr,
    input  t_entry               i_rd_entry,
    output t_mem_wr              o_wr,
    output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] o_wr_addr
);

    localparam int ADDR_W = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = CNT_W > LIMIT_W ? CNT_W : LIMIT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [ACT_W-1:0]    r_action, n_action;
    logic [NODE_W-1:0]   r_dest, n_dest;
    logic [NODE_W-1:0]   r_sender, n_sender;
    logic [HOPS_W-1:0]   r_hops, n_hops;
    logic [SEQ_W-1:0]    r_seq, n_seq;
    logic [TIME_W-1:0]   r_life, n_life;
    logic [NODE_W-1:0]   r_lost, n_lost;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_addr, n_addr;
    logic                r_pend, n_pend;
    logic [ADDR_W-1:0]   r_didx, n_didx;
    logic [CNT_W-1:0]    r_aff, n_aff;
    logic [STAT_W-1:0]   r_status, n_status;
    logic                r_out_vld, n_out_vld;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    logic [CNT_OUT_W-1:0] r_out_aff, n_out_aff;
    logic [CNT_OUT_W-1:0] r_out_used, n_out_used;

    // Shared compare unit: one 32-bit equality and magnitude compare whose
    // operands follow the action being worked on.
    logic [NODE_W-1:0] cmp_lhs, cmp_rhs;
    logic              cmp_eq, cmp_gt;
    logic              hops_lt;
    logic              table_full;
    logic              scan_end;
    logic              stop;

    always_comb begin
        case (r_action)
            ACT_REPLY: begin
                cmp_lhs = r_dest;
                cmp_rhs = i_rd_entry.dest;
            end
            ACT_ERROR: begin
                cmp_lhs = r_lost;
                cmp_rhs = i_rd_entry.nexthop;
            end
            default: begin
                cmp_lhs = r_now;
                cmp_rhs = i_rd_entry.expiry;
            end
        endcase
    end

    assign cmp_eq  = (cmp_lhs == cmp_rhs);
    assign cmp_gt  = (cmp_lhs > cmp_rhs);
    assign hops_lt = (r_hops < i_rd_entry.hops);

    assign table_full = (CMP_W'(r_count) >= CMP_W'(i_route_limit))
                     || (r_count >= CNT_W'(TABLE_DEPTH));
    assign scan_end   = !r_pend && (r_addr >= r_count);

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.affected     = r_out_aff;
    assign o_rsp.used_entries = r_out_used;

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_dest       = r_dest;
        n_sender     = r_sender;
        n_hops       = r_hops;
        n_seq        = r_seq;
        n_life       = r_life;
        n_lost       = r_lost;
        n_now        = r_now;
        n_count      = r_count;
        n_addr       = r_addr;
        n_pend       = r_pend;
        n_didx       = r_didx;
        n_aff        = r_aff;
        n_status     = r_status;
        n_out_vld    = r_out_vld && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_aff    = r_out_aff;
        n_out_used   = r_out_used;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_addr[ADDR_W-1:0];
        o_wr         = '0;
        o_wr_addr    = r_didx;
        stop         = 1'b0;

        o_wr.data.dest    = r_dest;
        o_wr.data.nexthop = r_sender;
        o_wr.data.hops    = r_hops;
        o_wr.data.seq     = r_seq;
        o_wr.data.expiry  = r_life;
        o_wr.data.act     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_action = i_req.action;
                    n_dest   = i_req.dest_node;
                    n_sender = i_req.sender_node;
                    n_hops   = i_req.hops;
                    n_seq    = i_req.seq_number;
                    n_life   = i_req.route_lifetime;
                    n_lost   = i_req.lost_node;
                    n_now    = i_req.time_now;
                    n_addr   = '0;
                    n_pend   = 1'b0;
                    n_aff    = '0;
                    n_status = ST_KEPT;
                    if (i_req.action inside {ACT_REPLY, ACT_ERROR, ACT_SWEEP}) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                // Check the entry read in the previous cycle.
                case (r_action)
                    ACT_REPLY: begin
                        if (r_pend && i_rd_entry.act && cmp_eq) begin
                            stop = 1'b1;
                            if (hops_lt) begin
                                o_wr.route_en = 1'b1;
                                n_status      = ST_IMPROVED;
                            end else begin
                                n_status = ST_KEPT;
                            end
                        end
                    end
                    ACT_ERROR: begin
                        if (r_pend && cmp_eq) begin
                            o_wr.act_en = 1'b1;
                            n_aff       = r_aff + CNT_W'(1);
                        end
                    end
                    default: begin
                        if (r_pend && i_rd_entry.act && cmp_gt) begin
                            o_wr.act_en = 1'b1;
                            n_aff       = r_aff + CNT_W'(1);
                        end
                    end
                endcase

                // Stop on a match, close the scan, or read the next entry.
                if (stop) begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end else if (scan_end) begin
                    if (r_action == ACT_REPLY) begin
                        if (table_full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_wr.key_en   = 1'b1;
                            o_wr.route_en = 1'b1;
                            o_wr.act_en   = 1'b1;
                            o_wr.data.act = 1'b1;
                            o_wr_addr     = r_count[ADDR_W-1:0];
                            n_count       = r_count + CNT_W'(1);
                            n_status      = ST_NEW;
                        end
                    end
                    n_state = S_DONE;
                end else if (r_addr < r_count) begin
                    o_rd_en = 1'b1;
                    n_didx  = r_addr[ADDR_W-1:0];
                    n_addr  = r_addr + CNT_W'(1);
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_status;
                    n_out_aff    = CNT_OUT_W'(r_aff);
                    n_out_used   = CNT_OUT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_dest       <= n_dest;
        r_sender     <= n_sender;
        r_hops       <= n_hops;
        r_seq        <= n_seq;
        r_life       <= n_life;
        r_lost       <= n_lost;
        r_now        <= n_now;
        r_addr       <= n_addr;
        r_didx       <= n_didx;
        r_aff        <= n_aff;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_aff    <= n_out_aff;
        r_out_used   <= n_out_used;
    end

endmodule

[rtl/aodv_route_table_core.sv]
// Channel   Direction  Word contents
// i_req     in         action, dest_node, sender_node, hops, seq_number,
//                      route_lifetime, lost_node, time_now
// o_rsp     out        status, affected, used_entries
// APB       in/out     route_limit register at byte address 0
//
// A full scan goes through accept, the first table read, one check per stored route,
// closing the scan and loading the output register (an empty table skips the read and
// the checks; the unused action code skips the scan). A route reply that finds its
// destination at entry k stops the scan there.
// Reset is synchronous and active low; it empties the table and sets route_limit to 64.
// A stalled output holds its word; the next item is taken and waits at the end of its scan.

module aodv_route_table_core import aodv_rt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    aodv_rt_req_if.sink       i_req,
    aodv_rt_rsp_if.source     o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int ADDR_W = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;

    // The route limit register. The user must change it only while the table
    // is idle (the block does not enforce this), so the sequencer reads it directly.
    logic [LIMIT_W-1:0] r_route_limit;
    logic               cfg_wr;
    logic               reg_sel;

    t_entry             rd_entry;
    t_mem_wr            mem_wr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;

    assign reg_sel = (paddr[CFG_AW-1:2] == REG_IDX_ROUTE_LIMIT);
    assign cfg_wr  = psel && penable && pwrite && reg_sel;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? CFG_DW'(r_route_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_limit <= ROUTE_LIMIT_RST;
        end else if (cfg_wr) begin
            r_route_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // The sequencer owns the scan, the shared comparator and the output
    // register; the table itself sits in a one-read, one-write memory.
    aodv_rt_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_route_limit (r_route_limit),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_entry    (rd_entry),
        .o_wr          (mem_wr),
        .o_wr_addr     (wr_addr)
    );

    aodv_rt_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry),
        .i_wr       (mem_wr),
        .i_wr_addr  (wr_addr)
    );

endmodule

[rtl/aodv_rt_chk.sv]
`include "aodv_route_table_core_assert.svh"

module aodv_rt_chk import aodv_rt_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [STAT_W-1:0]    i_out_status,
    input logic [CNT_OUT_W-1:0] i_out_used
);

    // One item at a time: after a word is taken, input stays closed.
    `RT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    // A result word waits until it is taken.
    `RT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    // Reset leaves no result word behind.
    `RT_ASSERT_ALWAYS(a_reset_empty, $past(!i_rst_n), !i_out_valid)

    // A new route always leaves at least one entry in use.
    `RT_ASSERT_NOW(a_new_counts, i_out_valid && (i_out_status == ST_NEW),
                   i_out_used != '0)

endmodule

bind aodv_route_table_core aodv_rt_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_status (o_rsp.status),
    .i_out_used   (o_rsp.used_entries)
);

[dv/aodv_rt_tb_pkg.sv]
package aodv_rt_tb_pkg;
    import aodv_rt_pkg::*;

    // The action field has one code that the block does not use.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [NODE_W-1:0] dest_node;
        logic [NODE_W-1:0] sender_node;
        logic [HOPS_W-1:0] hops;
        logic [SEQ_W-1:0]  seq_number;
        logic [TIME_W-1:0] route_lifetime;
        logic [NODE_W-1:0] lost_node;
        logic [TIME_W-1:0] time_now;
    } rt_request_t;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] affected;
        logic [CNT_OUT_W-1:0] used_entries;
    } rt_answer_t;

    // Shadow copy of the route table. Each accepted request word updates it and
    // queues the answer that the block must give.
    class route_table_tracker;
        logic [NODE_W-1:0] dest_tab[TABLE_DEPTH_DEF];
        logic [NODE_W-1:0] nexthop_tab[TABLE_DEPTH_DEF];
        logic [HOPS_W-1:0] hops_tab[TABLE_DEPTH_DEF];
        logic [SEQ_W-1:0]  seq_tab[TABLE_DEPTH_DEF];
        logic [TIME_W-1:0] expiry_tab[TABLE_DEPTH_DEF];
        logic              live_tab[TABLE_DEPTH_DEF];
        int unsigned       route_count;
        logic [LIMIT_W-1:0] limit_reg;
        rt_answer_t        expected_answers[$];
        int unsigned       mismatches;
        int unsigned       status_hits[4];
        int unsigned       action_hits[4];

        function new();
            route_count = 0;
            limit_reg   = ROUTE_LIMIT_RST;
            mismatches  = 0;
            foreach (status_hits[k]) begin
                status_hits[k] = 0;
                action_hits[k] = 0;
            end
        endfunction

        function void set_limit(input logic [LIMIT_W-1:0] value);
            limit_reg = value;
        endfunction

        function int unsigned pending();
            return expected_answers.size();
        endfunction

        function logic [STAT_W-1:0] apply_reply(input rt_request_t r);
            int unsigned cap;
            cap = (limit_reg > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : limit_reg;
            // Only the first live entry for the destination counts; dead ones
            // with the same destination are skipped, never revived.
            for (int i = 0; i < route_count; i++) begin
                if (live_tab[i] && dest_tab[i] == r.dest_node) begin
                    if (r.hops < hops_tab[i]) begin
                        nexthop_tab[i] = r.sender_node;
                        hops_tab[i]    = r.hops;
                        seq_tab[i]     = r.seq_number;
                        return ST_IMPROVED;
                    end
                    return ST_KEPT;
                end
            end
            if (route_count >= cap)
                return ST_FULL;
            dest_tab[route_count]    = r.dest_node;
            nexthop_tab[route_count] = r.sender_node;
            hops_tab[route_count]    = r.hops;
            seq_tab[route_count]     = r.seq_number;
            expiry_tab[route_count]  = r.route_lifetime;
            live_tab[route_count]    = 1'b1;
            route_count++;
            return ST_NEW;
        endfunction

        // Every entry through the lost node is counted, dead or alive.
        function logic [CNT_OUT_W-1:0] apply_error(input logic [NODE_W-1:0] lost);
            int unsigned n;
            n = 0;
            for (int i = 0; i < route_count; i++) begin
                if (nexthop_tab[i] == lost) begin
                    live_tab[i] = 1'b0;
                    n++;
                end
            end
            return CNT_OUT_W'(n);
        endfunction

        function logic [CNT_OUT_W-1:0] apply_sweep(input logic [TIME_W-1:0] now);
            int unsigned n;
            n = 0;
            for (int i = 0; i < route_count; i++) begin
                if (live_tab[i] && now > expiry_tab[i]) begin
                    live_tab[i] = 1'b0;
                    n++;
                end
            end
            return CNT_OUT_W'(n);
        endfunction

        function void note_request(input rt_request_t r);
            rt_answer_t a;
            a.status   = ST_KEPT;
            a.affected = '0;
            case (r.action)
                ACT_REPLY: a.status   = apply_reply(r);
                ACT_ERROR: a.affected = apply_error(r.lost_node);
                ACT_SWEEP: a.affected = apply_sweep(r.time_now);
                default: ;
            endcase
            a.used_entries = CNT_OUT_W'(route_count);
            action_hits[r.action]++;
            expected_answers.push_back(a);
        endfunction

        function void report_mismatch(input string field, input longint unsigned want,
                                      input longint unsigned got);
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        endfunction

        function void check_answer(input rt_answer_t got);
            rt_answer_t want;
            if (expected_answers.size() == 0) begin
                $error("unexpected result word: status %0d, affected %0d, used_entries %0d",
                       got.status, got.affected, got.used_entries);
                mismatches++;
                return;
            end
            want = expected_answers.pop_front();
            status_hits[want.status]++;
            if (got.status !== want.status)
                report_mismatch("status", want.status, got.status);
            if (got.affected !== want.affected)
                report_mismatch("affected", want.affected, got.affected);
            if (got.used_entries !== want.used_entries)
                report_mismatch("used_entries", want.used_entries, got.used_entries);
        endfunction
    endclass

endpackage

[dv/tb_aodv_route_table_core.sv]
module tb_aodv_route_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import aodv_rt_pkg::*;
    import aodv_rt_tb_pkg::*;

    // A scan reads each stored route once, so this settle time covers any
    // action still in flight.
    localparam int SETTLE_CYCLES = TABLE_DEPTH_DEF + 16;
    // Slowest correct run: ~1100 words, each with the longest sender gap,
    // a full scan and the longest receiver stall, plus phase boundaries.
    // The limit is several times that.
    localparam int CYCLE_LIMIT   = 600_000;
    localparam int PHASE_WORDS   = 150;
    localparam logic [CFG_AW-1:0] ROUTE_LIMIT_ADDR = CFG_AW'({REG_IDX_ROUTE_LIMIT, 2'b00});

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    aodv_rt_req_if req_ch ();
    aodv_rt_rsp_if rsp_ch ();

    aodv_route_table_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    route_table_tracker tracker = new();

    // Idling modes, changed per phase; some phases run one side at full rate.
    bit          req_gappy;
    bit          rsp_stalling;
    int unsigned limit_settings;
    longint unsigned cycles;

    // Small pools of node ids make destinations repeat and route errors hit
    // real next hops. The all-zeros and all-ones ids are always in them.
    logic [NODE_W-1:0] dest_pool[16];
    logic [NODE_W-1:0] sender_pool[8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung block or a lost word ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result monitor: every word accepted on the output goes to the checker.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_answer('{rsp_ch.status, rsp_ch.affected, rsp_ch.used_entries});
    end

    // Receiver: before each word it may hold ready low while stalling is on.
    // Ready changes only at falling edges, at most once per edge.
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        forever begin
            stall = rsp_stalling ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && rsp_ch.valid && rsp_ch.ready));
            @(negedge i_clk);
        end
    end

    // All fields random, so that the fields an action ignores still toggle.
    function automatic rt_request_t noise_fields();
        rt_request_t r;
        r.action         = ACT_W'($urandom_range(0, 3));
        r.dest_node      = $urandom;
        r.sender_node    = $urandom;
        r.hops           = HOPS_W'($urandom);
        r.seq_number     = $urandom;
        r.route_lifetime = $urandom;
        r.lost_node      = $urandom;
        r.time_now       = $urandom;
        return r;
    endfunction

    function automatic rt_request_t reply_req(input logic [NODE_W-1:0] dest,
                                              input logic [NODE_W-1:0] sender,
                                              input logic [HOPS_W-1:0] hops,
                                              input logic [SEQ_W-1:0] seq,
                                              input logic [TIME_W-1:0] life);
        rt_request_t r;
        r                = noise_fields();
        r.action         = ACT_REPLY;
        r.dest_node      = dest;
        r.sender_node    = sender;
        r.hops           = hops;
        r.seq_number     = seq;
        r.route_lifetime = life;
        return r;
    endfunction

    function automatic rt_request_t error_req(input logic [NODE_W-1:0] lost);
        rt_request_t r;
        r           = noise_fields();
        r.action    = ACT_ERROR;
        r.lost_node = lost;
        return r;
    endfunction

    function automatic rt_request_t sweep_req(input logic [TIME_W-1:0] now);
        rt_request_t r;
        r          = noise_fields();
        r.action   = ACT_SWEEP;
        r.time_now = now;
        return r;
    endfunction

    function automatic rt_request_t unused_req();
        rt_request_t r;
        r        = noise_fields();
        r.action = ACT_UNUSED;
        return r;
    endfunction

    // Random mix: mostly replies on pooled destinations, so routes get
    // improved and kept, with errors and sweeps that kill some of them.
    // Lifetimes lean high and sweep times low so that routes survive a while.
    function automatic rt_request_t random_request();
        rt_request_t r;
        int unsigned pick;
        r    = noise_fields();
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            r.action = ACT_REPLY;
            if ($urandom_range(0, 4) != 0)
                r.dest_node = dest_pool[$urandom_range(0, 15)];
            if ($urandom_range(0, 4) != 0)
                r.sender_node = sender_pool[$urandom_range(0, 7)];
            if ($urandom_range(0, 3) != 0)
                r.route_lifetime = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
        end else if (pick < 72) begin
            r.action = ACT_ERROR;
            if ($urandom_range(0, 6) != 0)
                r.lost_node = sender_pool[$urandom_range(0, 7)];
        end else if (pick < 95) begin
            r.action = ACT_SWEEP;
            if ($urandom_range(0, 9) < 7)
                r.time_now = $urandom_range(32'h7FFF_FFFF, 0);
        end else begin
            r.action = ACT_UNUSED;
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so words can follow back to back.
    task automatic send_word(input rt_request_t r);
        int gap;
        gap = req_gappy ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.action         <= r.action;
        req_ch.dest_node      <= r.dest_node;
        req_ch.sender_node    <= r.sender_node;
        req_ch.hops           <= r.hops;
        req_ch.seq_number     <= r.seq_number;
        req_ch.route_lifetime <= r.route_lifetime;
        req_ch.lost_node      <= r.lost_node;
        req_ch.time_now       <= r.time_now;
        req_ch.valid          <= 1'b1;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        tracker.note_request(r);
        @(negedge i_clk);
    endtask

    // Waits for every expected word, then for any scan that might still run.
    task automatic drain_and_settle();
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [CFG_AW-1:0] addr,
                              input logic [CFG_DW-1:0] wdata,
                              output logic [CFG_DW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Register writes happen only with the block idle. The value is read
    // back afterward and compared with what was written.
    task automatic set_route_limit(input logic [LIMIT_W-1:0] value);
        logic [CFG_DW-1:0] rd;
        drain_and_settle();
        apb_access(1'b1, ROUTE_LIMIT_ADDR, CFG_DW'(value), rd);
        tracker.set_limit(value);
        limit_settings++;
        apb_access(1'b0, ROUTE_LIMIT_ADDR, '0, rd);
        if (rd !== CFG_DW'(value))
            tracker.report_mismatch("route_limit readback", value, rd);
    endtask

    task automatic random_phase(input logic [LIMIT_W-1:0] limit, input int phase);
        set_route_limit(limit);
        req_gappy    = (phase % 4) != 1;
        rsp_stalling = (phase % 4) != 2;
        for (int n = 0; n < PHASE_WORDS; n++) begin
            // Now and then the sender holds off until the block is empty.
            if ($urandom_range(0, 59) == 0) begin
                req_ch.valid <= 1'b0;
                while (tracker.pending() != 0)
                    @(posedge i_clk);
                @(negedge i_clk);
            end
            send_word(random_request());
        end
        req_ch.valid <= 1'b0;
    endtask

    initial begin
        rt_request_t directed[$];
        cycles         = 0;
        limit_settings = 0;
        req_gappy      = 1'b1;
        rsp_stalling   = 1'b1;

        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_ch.valid          = 1'b0;
        req_ch.action         = ACT_REPLY;
        req_ch.dest_node      = '0;
        req_ch.sender_node    = '0;
        req_ch.hops           = '0;
        req_ch.seq_number     = '0;
        req_ch.route_lifetime = '0;
        req_ch.lost_node      = '0;
        req_ch.time_now       = '0;

        foreach (dest_pool[k])
            dest_pool[k] = $urandom;
        foreach (sender_pool[k])
            sender_pool[k] = $urandom;
        dest_pool[0]   = '0;
        dest_pool[15]  = '1;
        sender_pool[0] = '0;
        sender_pool[7] = '1;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset limit of 64. Two new routes with the
        // field extremes, then equal and higher hop counts (kept), two
        // improvements down to zero hops, and a short-lived third route.
        directed.push_back(reply_req('0, 32'hA5A5_0001, 8'd10, '0, '1));
        directed.push_back(reply_req('1, '1, 8'd255, '1, '0));
        directed.push_back(reply_req('0, 32'hA5A5_0003, 8'd10, 32'h11, 32'h22));
        directed.push_back(reply_req('0, 32'hA5A5_0004, 8'd255, 32'h33, 32'h44));
        directed.push_back(reply_req('0, 32'h5A5A_0002, 8'd3, 32'h55, 32'h66));
        directed.push_back(reply_req('0, '0, 8'd0, 32'h77, 32'h88));
        directed.push_back(reply_req(32'h1234_5678, 32'h5A5A_0002, 8'd7, 32'h99, 32'h1000));
        // A route error twice on the same node: the second one still counts
        // the entry even though it is already dead.
        directed.push_back(error_req('1));
        directed.push_back(error_req('1));
        // Reply for a destination whose only entry is dead: a fresh entry.
        directed.push_back(reply_req('1, 32'h5A5A_0002, 8'd9, 32'hAB, 32'h8000_0000));
        directed.push_back(error_req(32'hDEAD_BEEF));
        // Sweeps at time zero, exactly at an expiry, just past it, and at
        // the latest time.
        directed.push_back(sweep_req('0));
        directed.push_back(sweep_req(32'h1000));
        directed.push_back(sweep_req(32'h1001));
        directed.push_back(error_req(32'h5A5A_0002));
        directed.push_back(sweep_req('1));
        directed.push_back(unused_req());
        directed.push_back(reply_req('0, 32'hA5A5_0005, 8'd255, 32'hCD, 32'hEF));
        foreach (directed[k])
            send_word(directed[k]);
        req_ch.valid <= 1'b0;

        // A zero limit rejects new routes but still matches live ones.
        set_route_limit(7'd0);
        send_word(reply_req(32'hCAFE_0001, 32'h1, 8'd4, 32'h1, 32'h1));
        send_word(reply_req('0, 32'h2, 8'd0, 32'h2, 32'h2));
        req_ch.valid <= 1'b0;
        // A limit below the current count rejects new routes as well.
        set_route_limit(7'd2);
        send_word(reply_req(32'hCAFE_0002, 32'h3, 8'd4, 32'h3, 32'h3));
        req_ch.valid <= 1'b0;
        // A limit above the table depth behaves like the depth.
        set_route_limit(7'd127);
        send_word(reply_req(32'hCAFE_0003, '0, 8'd4, 32'h4, 32'h4));
        send_word(error_req('0));
        req_ch.valid <= 1'b0;

        // Random phases walk the limit up and down, so the table fills in
        // steps and spends time both below and at its limit.
        random_phase(7'd12, 0);
        random_phase(7'd30, 1);
        random_phase(7'd1, 2);
        random_phase(7'd0, 3);
        random_phase(7'd50, 4);
        random_phase(7'd127, 5);
        random_phase(7'd64, 6);

        drain_and_settle();
        $display("Result words: %0d new, %0d improved, %0d kept, %0d full; %0d routes stored.",
                 tracker.status_hits[ST_NEW], tracker.status_hits[ST_IMPROVED],
                 tracker.status_hits[ST_KEPT], tracker.status_hits[ST_FULL],
                 tracker.route_count);
        $display("Actions: %0d replies, %0d errors, %0d sweeps, %0d unused, %0d limit writes.",
                 tracker.action_hits[ACT_REPLY], tracker.action_hits[ACT_ERROR],
                 tracker.action_hits[ACT_SWEEP], tracker.action_hits[ACT_UNUSED],
                 limit_settings);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/aodv_rt_pkg.sv
rtl/aodv_rt_if.sv
rtl/aodv_rt_mem.sv
rtl/aodv_rt_seq.sv
rtl/aodv_route_table_core.sv
rtl/aodv_rt_chk.sv
dv/aodv_rt_tb_pkg.sv
dv/tb_aodv_route_table_core.sv
